### hw/rtl/rtbc_pkg.sv
// rtbc_pkg: shared types, constants and helper functions for the ranging timing budget block
// used by rtbc_div, rtbc_mul and ranging_timing_budget_calc; no dependencies
package rtbc_pkg;

    // fixed datapath widths
    localparam int MACRO_W   = 20;  // macro period in ns, at most 968532
    localparam int MCLK_W    = 16;  // macro period counts
    localparam int WORD_W    = 32;  // microsecond sums
    localparam int DIV_STEPS = 32;  // one quotient bit per cycle
    localparam int MUL_STEPS = 16;  // one multiplier bit per cycle
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

    // sequence step overheads in us
    localparam logic [31:0] OVH_START_GET = 32'd1910;
    localparam logic [31:0] OVH_START_SET = 32'd1320;
    localparam logic [31:0] OVH_END       = 32'd960;
    localparam logic [31:0] OVH_MSRC      = 32'd660;
    localparam logic [31:0] OVH_TCC       = 32'd590;
    localparam logic [31:0] OVH_DSS       = 32'd690;
    localparam logic [31:0] OVH_PRE       = 32'd660;
    localparam logic [31:0] OVH_FINAL     = 32'd550;
    localparam logic [31:0] BUDGET_MIN    = 32'd20000;
    localparam logic [31:0] ENC_HIGH_MASK = 32'hFFFFFF00;

    // macro period: (vclks * pclks * pll_ps + 500) / 1000
    localparam int          MACRO_VCLKS   = 2304;
    localparam int          PLL_CLK_PS    = 1655;
    localparam logic [31:0] MACRO_SCALE   = 32'(MACRO_VCLKS * PLL_CLK_PS);
    localparam logic [31:0] MACRO_ROUND   = 32'd500;
    localparam logic [MACRO_W-1:0] NS_PER_US = MACRO_W'(1000);

    // step enable bit positions
    localparam int EN_MSRC  = 2;
    localparam int EN_DSS   = 3;
    localparam int EN_TCC   = 4;
    localparam int EN_PRE   = 6;
    localparam int EN_FINAL = 7;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_LOW_BUDGET = 2'd1;
    localparam logic [1:0] STATUS_NO_ROOM    = 2'd2;
    localparam logic [1:0] STATUS_ZERO_MACRO = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MAC_PRE,
        ST_MAC_FIN,
        ST_MSRC_MUL,
        ST_MSRC_DIV,
        ST_PRE_MUL,
        ST_PRE_DIV,
        ST_SUM_TCC,
        ST_SUM_MSRC,
        ST_SUM_PRE,
        ST_BRANCH,
        ST_FIN_MUL,
        ST_FIN_DIV,
        ST_GET_DONE,
        ST_SET_CHECK,
        ST_SET_PREP,
        ST_SET_DIV,
        ST_ENCODE,
        ST_OUT
    } rtbc_state_t;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } rtbc_unit_stat_t;

    // laser period code to pclks, wraps at 8 bits
    function automatic logic [7:0] pclks_of(input logic [7:0] code);
        logic [7:0] t;
        begin
            t = code + 8'd1;
            return {t[6:0], 1'b0};
        end
    endfunction

    // numerator of the macro period rounding divide
    function automatic logic [31:0] macro_num(input logic [7:0] pclks);
        begin
            return 32'(MACRO_SCALE * 32'(pclks)) + MACRO_ROUND;
        end
    endfunction

    // mantissa byte shifted by the exponent in bits 11:8 within 16 bits, plus one; one if bits 15:12 are set
    function automatic logic [15:0] decode_to(input logic [15:0] code);
        logic [15:0] m;
        begin
            m = (code[15:12] == 4'd0) ? (16'(code[7:0]) << code[11:8]) : 16'd0;
            return m + 16'd1;
        end
    endfunction

endpackage

### hw/rtl/rtbc_div.sv
// rtbc_div: restoring divider, one quotient bit per cycle
// depends on rtbc_pkg
module rtbc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [31:0]                   dividend,
    input  logic [rtbc_pkg::MACRO_W-1:0]  divisor,
    output logic [31:0]                   quotient,
    output rtbc_pkg::rtbc_unit_stat_t     stat
);

    logic [rtbc_pkg::DIV_CNT_W-1:0] count_reg, count_next;
    logic                           done_reg, done_next;
    logic [rtbc_pkg::MACRO_W-1:0]   rem_reg, rem_next;
    logic [31:0]                    quo_reg, quo_next;
    logic [rtbc_pkg::MACRO_W-1:0]   dsr_reg, dsr_next;
    logic [rtbc_pkg::MACRO_W:0]     trial;
    logic                           fits;

    // one trial subtract per cycle, dividend bits shift out as quotient bits shift in
    always_comb begin
        trial      = {rem_reg, quo_reg[31]};
        fits       = trial >= {1'b0, dsr_reg};
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        if (start) begin
            rem_next   = '0;
            quo_next   = dividend;
            dsr_next   = divisor;
            count_next = rtbc_pkg::DIV_CNT_W'(rtbc_pkg::DIV_STEPS);
        end else if (count_reg != '0) begin
            rem_next   = fits ? rtbc_pkg::MACRO_W'(trial - {1'b0, dsr_reg})
                              : trial[rtbc_pkg::MACRO_W-1:0];
            quo_next   = {quo_reg[30:0], fits};
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == 1);
        end
    end

    // step counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // operand and partial result registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = count_reg != '0;
    assign stat.done = done_reg;

endmodule

### hw/rtl/rtbc_mul.sv
// rtbc_mul: shift-add multiplier, one multiplier bit per cycle, product wraps at 32 bits
// depends on rtbc_pkg
module rtbc_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rtbc_pkg::MCLK_W-1:0]   mplier,
    input  logic [rtbc_pkg::MACRO_W-1:0]  mcand,
    input  logic [31:0]                   addend,
    output logic [31:0]                   product,
    output rtbc_pkg::rtbc_unit_stat_t     stat
);

    logic [rtbc_pkg::MUL_CNT_W-1:0] count_reg, count_next;
    logic                           done_reg, done_next;
    logic [31:0]                    acc_reg, acc_next;
    logic [31:0]                    mcand_reg, mcand_next;
    logic [rtbc_pkg::MCLK_W-1:0]    mplier_reg, mplier_next;

    // add the shifted multiplicand when the low multiplier bit is set
    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        if (start) begin
            acc_next    = addend;
            mcand_next  = 32'(mcand);
            mplier_next = mplier;
            count_next  = rtbc_pkg::MUL_CNT_W'(rtbc_pkg::MUL_STEPS);
        end else if (count_reg != '0) begin
            acc_next    = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
            mcand_next  = {mcand_reg[30:0], 1'b0};
            mplier_next = mplier_reg >> 1;
            count_next  = count_reg - 1'b1;
            done_next   = (count_reg == 1);
        end
    end

    // step counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // accumulator and operand shift registers
    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign product   = acc_reg;
    assign stat.busy = count_reg != '0;
    assign stat.done = done_reg;

endmodule

### hw/rtl/ranging_timing_budget_calc.sv
// Ranging timing budget calculator: takes one get or set request at a time and
// returns one result per request. The input is ready again in the same cycle as the
// result is offered. Each 32-step division runs on the shared bit-serial divider:
// four always run (two macro periods, the msrc and pre-range times) and a fifth runs
// for the final-range time of a get with final range or the new timeout of a set
// with final range that passes its checks. Serial multiplies of 16 steps run on the
// multiplier, two, or three for a get with final range; then come the step sums and,
// for a set whose new timeout is computed, a timeout encode by normalize shifts.
// s_tready is high only while no request is in work; a finished result sits in the
// output register, so the next request can be taken while the result still waits
// for m_tready. The stored budget resets to zero.
// depends on rtbc_pkg, rtbc_div and rtbc_mul
module ranging_timing_budget_calc (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // step_enables[7:0], pre_period_code[15:8], final_period_code[23:16],
    // msrc_timeout_code[31:24], pre_timeout_code[47:32],
    // final_timeout_code[63:48], req_budget[95:64]
    input  logic [95:0]  s_tdata,
    // func[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], write_timeout[2], new_timeout_code[18:3], stored_budget[50:19],
    // zero pad [55:51]
    output logic [55:0]  m_tdata
);

    rtbc_pkg::rtbc_state_t state_reg, state_next;
    logic        launched_reg, launched_next;
    logic [31:0] stored_budget_reg, stored_budget_next;
    logic        m_tvalid_reg, m_tvalid_next;

    // request fields
    logic        func_reg;
    logic [7:0]  en_reg;
    logic [7:0]  pre_pc_reg;
    logic [7:0]  fin_pc_reg;
    logic [7:0]  msrc_code_reg;
    logic [15:0] pre_to_reg;
    logic [15:0] fin_to_reg;
    logic [31:0] req_reg;

    // working registers
    logic [rtbc_pkg::MACRO_W-1:0] pre_macro_reg;
    logic [rtbc_pkg::MACRO_W-1:0] fin_macro_reg;
    logic [31:0] msrc_us_reg;
    logic [31:0] pre_us_reg;
    logic [31:0] sum_reg;
    logic [31:0] work_reg;
    logic [15:0] mclks_reg;
    logic [15:0] enc_ls_reg;
    logic [3:0]  enc_ms_reg;
    logic [1:0]  status_reg;
    logic        wr_reg;
    logic [15:0] code_reg;
    logic [55:0] m_tdata_reg;

    // unit connections
    logic                          div_start;
    logic [31:0]                   div_dividend;
    logic [rtbc_pkg::MACRO_W-1:0]  div_divisor;
    logic [31:0]                   div_quo;
    rtbc_pkg::rtbc_unit_stat_t     div_stat;
    logic                          mul_start;
    logic [15:0]                   mul_mplier;
    logic [rtbc_pkg::MACRO_W-1:0]  mul_mcand;
    logic [31:0]                   mul_addend;
    logic [31:0]                   mul_product;
    rtbc_pkg::rtbc_unit_stat_t     mul_stat;

    // decoded flags and values
    logic        is_set, en_tcc, en_dss, en_msrc, en_pre, en_fin;
    logic [15:0] pre_mclks;
    logic [15:0] pre_add;
    logic [15:0] set_fm;
    logic        enc_done;
    logic        out_free;
    logic        s_accept;

    assign is_set    = func_reg;
    assign en_tcc    = en_reg[rtbc_pkg::EN_TCC];
    assign en_dss    = en_reg[rtbc_pkg::EN_DSS];
    assign en_msrc   = en_reg[rtbc_pkg::EN_MSRC];
    assign en_pre    = en_reg[rtbc_pkg::EN_PRE];
    assign en_fin    = en_reg[rtbc_pkg::EN_FINAL];
    assign pre_mclks = rtbc_pkg::decode_to(pre_to_reg);
    assign pre_add   = en_pre ? pre_mclks : 16'd0;
    assign set_fm    = div_quo[15:0] + pre_add;
    assign enc_done  = (mclks_reg == 16'd0)
                       || ((32'(enc_ls_reg) & rtbc_pkg::ENC_HIGH_MASK) == 32'd0);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    rtbc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    rtbc_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .mplier   (mul_mplier),
        .mcand    (mul_mcand),
        .addend   (mul_addend),
        .product  (mul_product),
        .stat     (mul_stat)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rtbc_pkg::ST_IDLE:      if (s_tvalid) state_next = rtbc_pkg::ST_MAC_PRE;
            rtbc_pkg::ST_MAC_PRE:   if (div_stat.done) state_next = rtbc_pkg::ST_MAC_FIN;
            rtbc_pkg::ST_MAC_FIN:   if (div_stat.done) state_next = rtbc_pkg::ST_MSRC_MUL;
            rtbc_pkg::ST_MSRC_MUL:  if (mul_stat.done) state_next = rtbc_pkg::ST_MSRC_DIV;
            rtbc_pkg::ST_MSRC_DIV:  if (div_stat.done) state_next = rtbc_pkg::ST_PRE_MUL;
            rtbc_pkg::ST_PRE_MUL:   if (mul_stat.done) state_next = rtbc_pkg::ST_PRE_DIV;
            rtbc_pkg::ST_PRE_DIV:   if (div_stat.done) state_next = rtbc_pkg::ST_SUM_TCC;
            rtbc_pkg::ST_SUM_TCC:   state_next = rtbc_pkg::ST_SUM_MSRC;
            rtbc_pkg::ST_SUM_MSRC:  state_next = rtbc_pkg::ST_SUM_PRE;
            rtbc_pkg::ST_SUM_PRE:   state_next = rtbc_pkg::ST_BRANCH;
            rtbc_pkg::ST_BRANCH: begin
                if (!is_set) begin
                    state_next = en_fin ? rtbc_pkg::ST_FIN_MUL : rtbc_pkg::ST_GET_DONE;
                end else if (req_reg < rtbc_pkg::BUDGET_MIN) begin
                    state_next = rtbc_pkg::ST_OUT;
                end else begin
                    state_next = en_fin ? rtbc_pkg::ST_SET_CHECK : rtbc_pkg::ST_OUT;
                end
            end
            rtbc_pkg::ST_FIN_MUL:   if (mul_stat.done) state_next = rtbc_pkg::ST_FIN_DIV;
            rtbc_pkg::ST_FIN_DIV:   if (div_stat.done) state_next = rtbc_pkg::ST_GET_DONE;
            rtbc_pkg::ST_GET_DONE:  state_next = rtbc_pkg::ST_OUT;
            rtbc_pkg::ST_SET_CHECK: begin
                if (sum_reg > req_reg || fin_macro_reg == '0) begin
                    state_next = rtbc_pkg::ST_OUT;
                end else begin
                    state_next = rtbc_pkg::ST_SET_PREP;
                end
            end
            rtbc_pkg::ST_SET_PREP:  state_next = rtbc_pkg::ST_SET_DIV;
            rtbc_pkg::ST_SET_DIV:   if (div_stat.done) state_next = rtbc_pkg::ST_ENCODE;
            rtbc_pkg::ST_ENCODE:    if (enc_done) state_next = rtbc_pkg::ST_OUT;
            rtbc_pkg::ST_OUT:       if (out_free) state_next = rtbc_pkg::ST_IDLE;
            default:                state_next = rtbc_pkg::ST_IDLE;
        endcase
    end

    // unit starts and operand selection
    always_comb begin
        s_tready     = state_reg == rtbc_pkg::ST_IDLE;
        div_start    = 1'b0;
        div_dividend = mul_product;
        div_divisor  = rtbc_pkg::NS_PER_US;
        mul_start    = 1'b0;
        mul_mplier   = pre_mclks;
        mul_mcand    = pre_macro_reg;
        mul_addend   = 32'(pre_macro_reg >> 1);
        case (state_reg)
            rtbc_pkg::ST_MAC_PRE: begin
                div_start    = !launched_reg;
                div_dividend = rtbc_pkg::macro_num(rtbc_pkg::pclks_of(pre_pc_reg));
            end
            rtbc_pkg::ST_MAC_FIN: begin
                div_start    = !launched_reg;
                div_dividend = rtbc_pkg::macro_num(rtbc_pkg::pclks_of(fin_pc_reg));
            end
            rtbc_pkg::ST_MSRC_MUL: begin
                mul_start  = !launched_reg;
                mul_mplier = 16'(msrc_code_reg) + 16'd1;
            end
            rtbc_pkg::ST_PRE_MUL: begin
                mul_start  = !launched_reg;
            end
            rtbc_pkg::ST_FIN_MUL: begin
                mul_start  = !launched_reg;
                mul_mplier = mclks_reg;
                mul_mcand  = fin_macro_reg;
                mul_addend = 32'(fin_macro_reg >> 1);
            end
            rtbc_pkg::ST_MSRC_DIV, rtbc_pkg::ST_PRE_DIV, rtbc_pkg::ST_FIN_DIV: begin
                div_start  = !launched_reg;
            end
            rtbc_pkg::ST_SET_DIV: begin
                div_start    = !launched_reg;
                div_dividend = work_reg;
                div_divisor  = fin_macro_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // control registers
    always_comb begin
        launched_next      = (state_next != state_reg) ? 1'b0
                             : (launched_reg || div_start || mul_start);
        stored_budget_next = stored_budget_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        if (state_reg == rtbc_pkg::ST_GET_DONE) begin
            stored_budget_next = sum_reg;
        end
        if (state_reg == rtbc_pkg::ST_ENCODE && enc_done) begin
            stored_budget_next = req_reg;
        end
        if (state_reg == rtbc_pkg::ST_OUT && out_free) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= rtbc_pkg::ST_IDLE;
            launched_reg      <= 1'b0;
            stored_budget_reg <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            launched_reg      <= launched_next;
            stored_budget_reg <= stored_budget_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            rtbc_pkg::ST_IDLE: begin
                if (s_accept) begin
                    func_reg      <= s_tuser;
                    en_reg        <= s_tdata[7:0];
                    pre_pc_reg    <= s_tdata[15:8];
                    fin_pc_reg    <= s_tdata[23:16];
                    msrc_code_reg <= s_tdata[31:24];
                    pre_to_reg    <= s_tdata[47:32];
                    fin_to_reg    <= s_tdata[63:48];
                    req_reg       <= s_tdata[95:64];
                    sum_reg       <= s_tuser ? rtbc_pkg::OVH_START_SET + rtbc_pkg::OVH_END
                                             : rtbc_pkg::OVH_START_GET + rtbc_pkg::OVH_END;
                    status_reg    <= rtbc_pkg::STATUS_OK;
                    wr_reg        <= 1'b0;
                    code_reg      <= 16'd0;
                end
            end
            rtbc_pkg::ST_MAC_PRE: begin
                if (div_stat.done) pre_macro_reg <= div_quo[rtbc_pkg::MACRO_W-1:0];
            end
            rtbc_pkg::ST_MAC_FIN: begin
                if (div_stat.done) fin_macro_reg <= div_quo[rtbc_pkg::MACRO_W-1:0];
            end
            rtbc_pkg::ST_MSRC_DIV: begin
                if (div_stat.done) msrc_us_reg <= div_quo;
            end
            rtbc_pkg::ST_PRE_DIV: begin
                if (div_stat.done) pre_us_reg <= div_quo;
            end
            // step overheads, one add per cycle
            rtbc_pkg::ST_SUM_TCC: begin
                if (en_tcc) sum_reg <= sum_reg + msrc_us_reg + rtbc_pkg::OVH_TCC;
            end
            rtbc_pkg::ST_SUM_MSRC: begin
                if (en_dss) begin
                    sum_reg <= sum_reg + {msrc_us_reg[30:0], 1'b0}
                               + {rtbc_pkg::OVH_DSS[30:0], 1'b0};
                end else if (en_msrc) begin
                    sum_reg <= sum_reg + msrc_us_reg + rtbc_pkg::OVH_MSRC;
                end
            end
            rtbc_pkg::ST_SUM_PRE: begin
                if (en_pre) sum_reg <= sum_reg + pre_us_reg + rtbc_pkg::OVH_PRE;
            end
            rtbc_pkg::ST_BRANCH: begin
                mclks_reg <= rtbc_pkg::decode_to(fin_to_reg) - pre_add;
                if (is_set) begin
                    if (req_reg < rtbc_pkg::BUDGET_MIN) begin
                        status_reg <= rtbc_pkg::STATUS_LOW_BUDGET;
                    end else if (en_fin) begin
                        sum_reg <= sum_reg + rtbc_pkg::OVH_FINAL;
                    end
                end
            end
            rtbc_pkg::ST_FIN_DIV: begin
                if (div_stat.done) sum_reg <= sum_reg + div_quo + rtbc_pkg::OVH_FINAL;
            end
            rtbc_pkg::ST_SET_CHECK: begin
                if (sum_reg > req_reg) begin
                    status_reg <= rtbc_pkg::STATUS_NO_ROOM;
                end else if (fin_macro_reg == '0) begin
                    status_reg <= rtbc_pkg::STATUS_ZERO_MACRO;
                end
                work_reg <= req_reg - sum_reg;
            end
            // remaining us times 1000 plus half a macro period, wraps at 32 bits
            rtbc_pkg::ST_SET_PREP: begin
                work_reg <= {work_reg[21:0], 10'd0} - {work_reg[26:0], 5'd0}
                            + {work_reg[28:0], 3'd0} + 32'(fin_macro_reg >> 1);
            end
            rtbc_pkg::ST_SET_DIV: begin
                if (div_stat.done) begin
                    mclks_reg  <= set_fm;
                    enc_ls_reg <= set_fm - 16'd1;
                    enc_ms_reg <= 4'd0;
                end
            end
            // normalize the mantissa into the low byte, one shift per cycle
            rtbc_pkg::ST_ENCODE: begin
                if (mclks_reg == 16'd0) begin
                    code_reg <= 16'd0;
                    wr_reg   <= 1'b1;
                end else if (!enc_done) begin
                    enc_ls_reg <= enc_ls_reg >> 1;
                    enc_ms_reg <= enc_ms_reg + 4'd1;
                end else begin
                    code_reg <= {4'd0, enc_ms_reg, enc_ls_reg[7:0]};
                    wr_reg   <= 1'b1;
                end
            end
            rtbc_pkg::ST_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= {5'd0, stored_budget_reg, code_reg, wr_reg, status_reg};
                end
            end
            default: begin
                wr_reg <= wr_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the divider and the multiplier take turns
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(div_stat.busy && mul_stat.busy))
        else $error("divider and multiplier busy together");

    // one request at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input taken while a request is in work");

    // a new timeout code only comes with a good status
    a_write_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == rtbc_pkg::STATUS_OK))
        else $error("timeout code written with an error status");

    // a 16-bit count needs at most eight normalize shifts
    a_enc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rtbc_pkg::ST_ENCODE) |-> (enc_ms_reg <= 4'd8))
        else $error("timeout encode exponent out of range");

endmodule
